@@ rtl/gdp_pkg.sv @@
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared constants, codes and types of the graph walk and path count unit.
// ----------------------------------------------------------------------------
package gdp_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int MAX_DEGREE   = 16;

	localparam int VTX_W  = 4;
	localparam int NV_W   = 5;
	localparam int POS_W  = $clog2(MAX_DEGREE);
	localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
	localparam int SP_W   = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W = VTX_W + POS_W;
	localparam int CNT_W  = 32;

	localparam logic [NV_W-1:0]  NV_RESET = NV_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0] CNT_SAT  = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_WALK  = 2'd1,
		KIND_COUNT = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_SAT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WTOP,
		ST_WUSE,
		ST_WFIN,
		ST_CTOP,
		ST_CUSE,
		ST_CFIN
	} state_t;

endpackage

@@ rtl/gdp_in_if.sv @@
// ----------------------------------------------------------------------------
// gdp_in_if
// Request channel: one command item per transfer.
// ----------------------------------------------------------------------------
interface gdp_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [gdp_pkg::VTX_W-1:0] vertex_a;
	logic [gdp_pkg::VTX_W-1:0] vertex_b;

	modport source (output valid, output kind, output vertex_a, output vertex_b, input ready);
	modport sink   (input valid, input kind, input vertex_a, input vertex_b, output ready);
endinterface

@@ rtl/gdp_out_if.sv @@
// ----------------------------------------------------------------------------
// gdp_out_if
// Result channel: one result item per transfer.
// ----------------------------------------------------------------------------
interface gdp_out_if;
	logic                      valid;
	logic                      ready;
	logic [gdp_pkg::VTX_W-1:0] visited_vertex;
	logic [gdp_pkg::CNT_W-1:0] npaths;
	logic [1:0]                status;
	logic                      last;

	modport source (output valid, output visited_vertex, output npaths, output status,
		output last, input ready);
	modport sink   (input valid, input visited_vertex, input npaths, input status,
		input last, output ready);
endinterface

@@ rtl/graph_dfs_and_path_counter_unit.sv @@
// ----------------------------------------------------------------------------
// graph_dfs_and_path_counter_unit
// Directed graph store with depth-first walk and simple path count.
// ----------------------------------------------------------------------------
// The unit holds one command at a time; req.ready is high only while it is
// idle. An add-edge command passes through the decode state and waits there
// until the output register can take its result. A walk or a count runs a
// stack sequencer that handles each stored neighbour in two steps (read the
// neighbour memory, then use the entry) and pops the stack in a step of its
// own. A count enumerates every simple path by backtracking, so its time
// grows with the number of partial paths in the graph; it stops early once
// the count saturates. Results pass through one output register, and the
// sequencer holds only when it must hand over a result while that register
// is full.
// No clearing pass is needed after reset.
module graph_dfs_and_path_counter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [gdp_pkg::NV_W-1:0]  cfg_wdata,
	gdp_in_if.sink                    req,
	gdp_out_if.source                 rsp
);
	import gdp_pkg::*;

	state_t state_q, state_d;

	// Configuration and decoded vertex limit.
	logic [NV_W-1:0] nv_q;
	logic [NV_W-1:0] n_eff;

	// Latched command.
	kind_t            kind_q;
	logic [VTX_W-1:0] a_q, b_q;

	// Graph store: degree per vertex in flops, neighbour lists in a memory.
	logic [DEG_W-1:0] deg_q [MAX_VERTICES];
	logic [VTX_W-1:0] nbr_mem [2**ADDR_W];
	logic [VTX_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;

	// Walk stack: vertex and next list position, plus visited marks.
	logic [VTX_W-1:0] stk_v_q   [MAX_VERTICES];
	logic [DEG_W-1:0] stk_pos_q [MAX_VERTICES];
	logic [SP_W-1:0]  sp_q;
	logic [MAX_VERTICES-1:0] vis_q;

	logic [VTX_W-1:0] pend_v_q;
	logic [CNT_W-1:0] cnt_q;

	// Output register.
	logic             out_valid_q;
	logic [VTX_W-1:0] out_vertex_q;
	logic [CNT_W-1:0] out_count_q;
	logic [1:0]       out_status_q;
	logic             out_last_q;

	// Shared step logic.
	logic             out_free;
	logic             a_bad, b_bad, full;
	logic [SP_W-1:0]  sp_m1;
	logic [VTX_W-1:0] top_idx, top_v;
	logic [DEG_W-1:0] top_pos;
	logic             top_end, sp_zero, u_new, cnt_sat;

	// Actions decided per cycle.
	logic             emit_req, emit;
	logic [VTX_W-1:0] e_vertex;
	logic [CNT_W-1:0] e_count;
	status_t          e_status;
	logic             e_last;
	logic             do_add, do_init, cnt_one, adv, pop, push_w, push_c, inc_cnt;

	// Zero means one vertex; anything above the maximum clamps to it.
	always_comb begin
		if (nv_q == '0) begin
			n_eff = NV_W'(1);
		end else if (nv_q > NV_RESET) begin
			n_eff = NV_RESET;
		end else begin
			n_eff = nv_q;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign a_bad    = {1'b0, a_q} >= n_eff;
	assign b_bad    = {1'b0, b_q} >= n_eff;
	assign full     = deg_q[a_q] >= DEG_W'(MAX_DEGREE);
	assign sp_m1    = sp_q - SP_W'(1);
	assign top_idx  = sp_m1[VTX_W-1:0];
	assign top_v    = stk_v_q[top_idx];
	assign top_pos  = stk_pos_q[top_idx];
	assign top_end  = top_pos >= deg_q[top_v];
	assign sp_zero  = sp_q == '0;
	assign rd_addr  = {top_v, top_pos[POS_W-1:0]};
	assign u_new    = ({1'b0, rd_q} < n_eff) && !vis_q[rd_q];
	assign cnt_sat  = cnt_q == CNT_SAT;

	assign req.ready = state_q == ST_IDLE;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (kind_q)
					KIND_ADD: begin
						if (out_free) state_d = ST_IDLE;
					end
					KIND_WALK: begin
						if (a_bad) begin
							if (out_free) state_d = ST_IDLE;
						end else begin
							state_d = ST_WTOP;
						end
					end
					KIND_COUNT: begin
						if (a_bad || b_bad) begin
							if (out_free) state_d = ST_IDLE;
						end else if (a_q == b_q) begin
							state_d = ST_CFIN;
						end else begin
							state_d = ST_CTOP;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_WTOP: begin
				if (sp_zero) state_d = ST_WFIN;
				else if (!top_end) state_d = ST_WUSE;
			end
			ST_WUSE: begin
				if (!(u_new && !out_free)) state_d = ST_WTOP;
			end
			ST_WFIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_CTOP: begin
				if (sp_zero || cnt_sat) state_d = ST_CFIN;
				else if (!top_end) state_d = ST_CUSE;
			end
			ST_CUSE: state_d = ST_CTOP;
			ST_CFIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Actions and result fields.
	always_comb begin
		emit_req = 1'b0;
		e_vertex = '0;
		e_count  = '0;
		e_status = STAT_OK;
		e_last   = 1'b1;
		do_add   = 1'b0;
		do_init  = 1'b0;
		cnt_one  = 1'b0;
		adv      = 1'b0;
		pop      = 1'b0;
		push_w   = 1'b0;
		push_c   = 1'b0;
		inc_cnt  = 1'b0;
		unique case (state_q)
			ST_DECODE: begin
				unique case (kind_q)
					KIND_ADD: begin
						emit_req = 1'b1;
						if (a_bad || b_bad) begin
							e_status = STAT_RANGE;
						end else if (full) begin
							e_status = STAT_FULL;
						end else begin
							do_add = out_free;
						end
					end
					KIND_WALK: begin
						if (a_bad) begin
							emit_req = 1'b1;
							e_status = STAT_RANGE;
						end else begin
							do_init = 1'b1;
						end
					end
					KIND_COUNT: begin
						if (a_bad || b_bad) begin
							emit_req = 1'b1;
							e_status = STAT_RANGE;
						end else if (a_q == b_q) begin
							cnt_one = 1'b1;
						end else begin
							do_init = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_WTOP, ST_CTOP: begin
				if (!sp_zero && !(state_q == ST_CTOP && cnt_sat)) begin
					pop = top_end;
					adv = !top_end;
				end
			end
			ST_WUSE: begin
				if (u_new) begin
					// Hand over the previous vertex; the new one waits as pending.
					emit_req = 1'b1;
					e_vertex = pend_v_q;
					e_last   = 1'b0;
					push_w   = out_free;
				end
			end
			ST_WFIN: begin
				emit_req = 1'b1;
				e_vertex = pend_v_q;
			end
			ST_CUSE: begin
				if (u_new) begin
					inc_cnt = rd_q == b_q;
					push_c  = rd_q != b_q;
				end
			end
			ST_CFIN: begin
				emit_req = 1'b1;
				e_count  = cnt_q;
				e_status = cnt_sat ? STAT_SAT : STAT_OK;
			end
			default: ;
		endcase
		emit = emit_req && out_free;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nv_q        <= NV_RESET;
			sp_q        <= '0;
			vis_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_VERTICES; i++) deg_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) nv_q <= cfg_wdata;
			if (do_add) deg_q[a_q] <= deg_q[a_q] + DEG_W'(1);
			if (do_init) begin
				// Clear marks and seed the stack with the start vertex.
				vis_q       <= MAX_VERTICES'(1) << a_q;
				sp_q        <= SP_W'(1);
				cnt_q       <= '0;
			end
			if (cnt_one) cnt_q <= CNT_W'(1);
			if (pop) begin
				sp_q <= sp_m1;
				// Backtrack: the count frees the vertex, the walk keeps it.
				if (state_q == ST_CTOP) vis_q[top_v] <= 1'b0;
			end
			if (push_w || push_c) begin
				sp_q        <= sp_q + SP_W'(1);
				vis_q[rd_q] <= 1'b1;
			end
			if (inc_cnt) cnt_q <= cnt_q + CNT_W'(1);
			if (emit) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers and the neighbour memory.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= kind_t'(req.kind);
			a_q    <= req.vertex_a;
			b_q    <= req.vertex_b;
		end
		if (do_add) nbr_mem[{a_q, deg_q[a_q][POS_W-1:0]}] <= b_q;
		// Hold the neighbour while the use step waits on the output register.
		if (adv) rd_q <= nbr_mem[rd_addr];
		if (do_init) begin
			stk_v_q[0]   <= a_q;
			stk_pos_q[0] <= '0;
			pend_v_q     <= a_q;
		end
		if (adv) stk_pos_q[top_idx] <= top_pos + DEG_W'(1);
		if (push_w || push_c) begin
			stk_v_q[sp_q[VTX_W-1:0]]   <= rd_q;
			stk_pos_q[sp_q[VTX_W-1:0]] <= '0;
		end
		if (push_w) pend_v_q <= rd_q;
		if (emit) begin
			out_vertex_q <= e_vertex;
			out_count_q  <= e_count;
			out_status_q <= e_status;
			out_last_q   <= e_last;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.visited_vertex = out_vertex_q;
	assign rsp.npaths         = out_count_q;
	assign rsp.status         = out_status_q;
	assign rsp.last           = out_last_q;

	// The stack never holds more entries than there are vertices.
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(MAX_VERTICES))
		else $error("walk stack overflow");

	// A neighbour is used only right after its memory read was issued.
	a_use_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WUSE && !$past(state_q == ST_WUSE)) |-> $past(state_q == ST_WTOP))
		else $error("neighbour used without a read");

	// The stack top is marked visited during a walk or a count.
	a_top_marked: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WTOP || state_q == ST_CTOP) && !sp_zero) |-> vis_q[top_v])
		else $error("stack top not marked");

	// The path count never moves backward while paths are enumerated.
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CUSE) |=> cnt_q >= $past(cnt_q))
		else $error("path count decreased");

endmodule
